// File: rtl/sorted_priority_queue_top_assert.svh
// Assertion macros used by the checker of the sorted priority queue.
// Each macro takes a label, the clock, the active-low reset, a condition and a consequence.
`ifndef SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH

// The consequence holds in the same cycle as the condition.
`define SPQ_ASSERT_SAME(lbl, clk_s, rstn_s, cond, conseq) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (cond) |-> (conseq)) \
        else $error("sorted priority queue check failed");

// The consequence holds in the cycle after the condition.
`define SPQ_ASSERT_NEXT(lbl, clk_s, rstn_s, cond, conseq) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (cond) |=> (conseq)) \
        else $error("sorted priority queue check failed");

`endif

// File: rtl/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Sizes, command and status codes, and the control and status bundles that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int ELEM_W   = 32;
    localparam int PRIO_W   = 16;
    localparam int CMD_W    = 4;
    localparam int STAT_W   = 2;
    localparam int CNT_W    = 5;
    localparam int IDX_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = $clog2(CAPACITY);

    localparam logic [CMD_W-1:0] CMD_INSERT       = 4'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE_FIRST = 4'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE_ELEM  = 4'd2;
    localparam logic [CMD_W-1:0] CMD_CHANGE_PRIO  = 4'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR        = 4'd4;
    localparam logic [CMD_W-1:0] CMD_CONTAINS     = 4'd5;
    localparam logic [CMD_W-1:0] CMD_SIZE         = 4'd6;
    localparam logic [CMD_W-1:0] CMD_FIRST        = 4'd7;
    localparam logic [CMD_W-1:0] CMD_NEXT         = 4'd8;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic              load_req;
        logic              idx_inc;
        logic              idx_clr;
        logic              drop;
        logic              insert;
        logic              clear;
        logic              iter_zero;
        logic              iter_inc;
        logic              rd_iter;
        logic              out_load;
        logic [STAT_W-1:0] out_status;
        logic              out_found;
        logic              out_eout;
    } spq_ctl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             full;
        logic             empty;
        logic             idx_end;
        logic             val_eq;
        logic             prio_eq;
        logic             ins_stop;
        logic             next_ok;
    } spq_sts_t;

endpackage

// File: rtl/spq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue datapath
// Entry storage as a shifting row, the scan index, the iterator, the latched
// request and the result registers.
// ----------------------------------------------------------------------------
module spq_datapath
    import spq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CMD_W-1:0]  command,
    input  logic [ELEM_W-1:0] element,
    input  logic [PRIO_W-1:0] priority_req,
    input  logic [PRIO_W-1:0] cur_priority,
    input  spq_ctl_t          ctl,
    output spq_sts_t          sts,
    output logic              done,
    output logic [STAT_W-1:0] status,
    output logic              found,
    output logic [ELEM_W-1:0] element_out,
    output logic [CNT_W-1:0]  count
);

    logic [ELEM_W-1:0] val_reg [CAPACITY];
    logic [PRIO_W-1:0] pri_reg [CAPACITY];
    logic [ELEM_W-1:0] val_below [CAPACITY];
    logic [ELEM_W-1:0] val_above [CAPACITY];
    logic [PRIO_W-1:0] pri_below [CAPACITY];
    logic [PRIO_W-1:0] pri_above [CAPACITY];

    logic [CMD_W-1:0]  cmd_reg;
    logic [ELEM_W-1:0] elem_reg;
    logic [PRIO_W-1:0] newp_reg;
    logic [PRIO_W-1:0] oldp_reg;

    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  iter_reg, iter_next;
    logic [IDX_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  iter_plus;
    logic [ADDR_W-1:0] rd_addr;
    logic [ELEM_W-1:0] rd_val;
    logic [PRIO_W-1:0] rd_pri;

    logic              done_reg;
    logic [STAT_W-1:0] status_reg;
    logic              found_reg;
    logic [ELEM_W-1:0] eout_reg;
    logic [CNT_W-1:0]  cnt_out_reg;

    // Neighbor taps of each entry for the shift by one place.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_tap
        if (g == 0) begin : g_first
            assign val_below[g] = val_reg[g];
            assign pri_below[g] = pri_reg[g];
        end
        else begin : g_rest
            assign val_below[g] = val_reg[g-1];
            assign pri_below[g] = pri_reg[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign val_above[g] = val_reg[g];
            assign pri_above[g] = pri_reg[g];
        end
        else begin : g_inner
            assign val_above[g] = val_reg[g+1];
            assign pri_above[g] = pri_reg[g+1];
        end
    end

    assign iter_plus = iter_reg + IDX_W'(1);
    assign rd_addr   = ctl.rd_iter ? iter_plus[ADDR_W-1:0] : idx_reg[ADDR_W-1:0];
    assign rd_val    = val_reg[rd_addr];
    assign rd_pri    = pri_reg[rd_addr];

    assign sts.cmd      = cmd_reg;
    assign sts.full     = (count_reg == IDX_W'(CAPACITY));
    assign sts.empty    = (count_reg == '0);
    assign sts.idx_end  = (idx_reg >= count_reg);
    assign sts.val_eq   = (rd_val == elem_reg);
    assign sts.prio_eq  = (rd_pri == oldp_reg);
    assign sts.ins_stop = (rd_pri < newp_reg);
    assign sts.next_ok  = (iter_plus < count_reg);

    always_comb
    begin
        idx_next = idx_reg;
        if (ctl.load_req || ctl.idx_clr)
        begin
            idx_next = '0;
        end
        else if (ctl.idx_inc)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end

        count_next = count_reg;
        if (ctl.clear)
        begin
            count_next = '0;
        end
        else if (ctl.drop)
        begin
            count_next = count_reg - IDX_W'(1);
        end
        else if (ctl.insert)
        begin
            count_next = count_reg + IDX_W'(1);
        end

        iter_next = iter_reg;
        if (ctl.clear || ctl.iter_zero)
        begin
            iter_next = '0;
        end
        else if (ctl.iter_inc)
        begin
            iter_next = iter_plus;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            count_reg <= '0;
            iter_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            count_reg <= count_next;
            iter_reg  <= iter_next;
            done_reg  <= ctl.out_load;
        end
    end

    // Request latch and result registers.
    always_ff @(posedge clk)
    begin
        if (ctl.load_req)
        begin
            cmd_reg  <= command;
            elem_reg <= element;
            newp_reg <= priority_req;
            oldp_reg <= cur_priority;
        end
        if (ctl.out_load)
        begin
            status_reg  <= ctl.out_status;
            found_reg   <= ctl.out_found;
            eout_reg    <= ctl.out_eout ? rd_val : '0;
            cnt_out_reg <= CNT_W'(count_next);
        end
    end

    // Entries above the drop point move down by one; entries above the
    // insert point move up by one and the new entry lands at the index.
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < CAPACITY; j++)
        begin
            if (ctl.drop && (IDX_W'(j) >= idx_reg))
            begin
                val_reg[j] <= val_above[j];
                pri_reg[j] <= pri_above[j];
            end
            else if (ctl.insert && (IDX_W'(j) == idx_reg))
            begin
                val_reg[j] <= elem_reg;
                pri_reg[j] <= newp_reg;
            end
            else if (ctl.insert && (IDX_W'(j) > idx_reg))
            begin
                val_reg[j] <= val_below[j];
                pri_reg[j] <= pri_below[j];
            end
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign found       = found_reg;
    assign element_out = eout_reg;
    assign count       = cnt_out_reg;

endmodule

// File: rtl/spq_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue controller
// Decodes the latched command and sequences the search and placement scans.
// ----------------------------------------------------------------------------
module spq_controller
    import spq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  spq_sts_t sts,
    output spq_ctl_t ctl,
    output logic     busy
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_FIND  = 2'd2;
    localparam logic [1:0] S_PLACE = 2'd3;

    logic [1:0] state_reg, state_next;

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load_req = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ctl.out_load   = 1'b1;
                ctl.out_status = ST_OK;
                state_next     = S_IDLE;
                case (sts.cmd)
                    CMD_INSERT:
                    begin
                        if (sts.full)
                        begin
                            ctl.out_status = ST_FULL;
                        end
                        else
                        begin
                            ctl.out_load = 1'b0;
                            state_next   = S_PLACE;
                        end
                    end
                    CMD_REMOVE_FIRST:
                    begin
                        if (sts.empty)
                        begin
                            ctl.out_status = ST_EMPTY;
                        end
                        else
                        begin
                            ctl.drop = 1'b1;
                        end
                    end
                    CMD_REMOVE_ELEM, CMD_CHANGE_PRIO, CMD_CONTAINS:
                    begin
                        ctl.out_load = 1'b0;
                        state_next   = S_FIND;
                    end
                    CMD_CLEAR:
                    begin
                        ctl.clear = 1'b1;
                    end
                    CMD_FIRST:
                    begin
                        if (sts.empty)
                        begin
                            ctl.out_status = ST_EMPTY;
                        end
                        else
                        begin
                            ctl.iter_zero = 1'b1;
                            ctl.out_eout  = 1'b1;
                        end
                    end
                    CMD_NEXT:
                    begin
                        ctl.rd_iter = 1'b1;
                        if (sts.next_ok)
                        begin
                            ctl.iter_inc = 1'b1;
                            ctl.out_eout = 1'b1;
                        end
                        else
                        begin
                            ctl.out_status = ST_EMPTY;
                        end
                    end
                    default:
                    begin
                        ctl.out_status = ST_OK;
                    end
                endcase
            end
            S_FIND:
            begin
                if (sts.idx_end)
                begin
                    ctl.out_load   = 1'b1;
                    ctl.out_status = (sts.cmd == CMD_CONTAINS) ? ST_OK : ST_NOT_FOUND;
                    state_next     = S_IDLE;
                end
                else if (sts.val_eq && ((sts.cmd != CMD_CHANGE_PRIO) || sts.prio_eq))
                begin
                    ctl.out_status = ST_OK;
                    if (sts.cmd == CMD_CONTAINS)
                    begin
                        ctl.out_load  = 1'b1;
                        ctl.out_found = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else if (sts.cmd == CMD_CHANGE_PRIO)
                    begin
                        ctl.drop    = 1'b1;
                        ctl.idx_clr = 1'b1;
                        state_next  = S_PLACE;
                    end
                    else
                    begin
                        ctl.drop     = 1'b1;
                        ctl.out_load = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    ctl.idx_inc = 1'b1;
                end
            end
            S_PLACE:
            begin
                if (sts.idx_end || sts.ins_stop)
                begin
                    ctl.insert     = 1'b1;
                    ctl.out_load   = 1'b1;
                    ctl.out_status = ST_OK;
                    state_next     = S_IDLE;
                end
                else
                begin
                    ctl.idx_inc = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// File: rtl/sorted_priority_queue_top.sv
`timescale 1ns / 1ps
// Size, clear, first, next, remove first and undecoded commands finish without a scan;
// insert runs a placement scan, contains and remove element run a search scan, and
// change priority runs a search scan and then a placement scan.
// One command at a time; busy stays high until the done beat, which cannot stall.
// Reset clears the entry count and the iterator; entry storage is left as it is.
// ----------------------------------------------------------------------------
// Sorted priority queue
// Bounded queue kept sorted by priority, highest first, with equal priorities
// in arrival order; supports insert, removal, re-prioritizing, lookup and
// iteration.
// ----------------------------------------------------------------------------
//
// Structure: the controller decodes each accepted command and steps a scan
// index through the stored entries, one entry per cycle. The datapath keeps
// the entries as a row of registers; removal and insertion shift every entry
// past the chosen index by one place at once. A search scan compares
// the entry at the index with the requested value (and current priority for a
// change), and a placement scan stops at the first entry whose priority is
// lower than the new one, so equal priorities keep their arrival order.
// Change priority runs a search scan, removes the match, then runs a
// placement scan with the new priority.
//
// The done beat carries status, the found flag, the element returned by first
// or next (zero otherwise) and the entry count after the command. A new start
// is taken in the same cycle as a done beat, since busy is already low then.
module sorted_priority_queue_top
    import spq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [CMD_W-1:0]  command,
    input  logic [ELEM_W-1:0] element,
    input  logic [PRIO_W-1:0] priority_req,
    input  logic [PRIO_W-1:0] cur_priority,
    output logic              done,
    output logic [STAT_W-1:0] status,
    output logic              found,
    output logic [ELEM_W-1:0] element_out,
    output logic [CNT_W-1:0]  count
);

    spq_ctl_t ctl;
    spq_sts_t sts;

    // Sequencer: owns busy and issues one control bundle per cycle.
    spq_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy)
    );

    // Storage, scan compare and result registers.
    spq_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .command      (command),
        .element      (element),
        .priority_req (priority_req),
        .cur_priority (cur_priority),
        .ctl          (ctl),
        .sts          (sts),
        .done         (done),
        .status       (status),
        .found        (found),
        .element_out  (element_out),
        .count        (count)
    );

endmodule

// File: rtl/spq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_top_assert.svh"

module spq_checker
    import spq_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input logic [STAT_W-1:0] status,
    input logic              found,
    input logic [CNT_W-1:0]  count
);

    // An accepted command keeps the block busy in the following cycle.
    `SPQ_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)

    // The done beat coincides with the return to idle.
    `SPQ_ASSERT_SAME(a_done_idle, clk, rst_n, done, !busy)

    // A full report only comes from a queue at capacity.
    `SPQ_ASSERT_SAME(a_full_count, clk, rst_n, done && (status == ST_FULL),
        count == CNT_W'(CAPACITY))

    // A hit from contains is always a success.
    `SPQ_ASSERT_SAME(a_found_ok, clk, rst_n, done && found, status == ST_OK)

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (.*);
